// File: rtl/qrtlv_pkg.sv
package qrtlv_pkg;

	// Field widths fixed by the payload format.
	localparam int CHAR_W    = 8;
	localparam int TAG_W     = 16;
	localparam int CRC_W     = 16;
	localparam int LEN_W     = 7;
	localparam int COUNT_W   = 7;
	localparam int INDEX_W   = 6;
	localparam int OFFSET_W  = 9;
	localparam int POS_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE_TAG = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [COUNT_W-1:0] MAX_ELEMENTS_RESET  = 7'd64;
	localparam logic [TAG_W-1:0]   SIGNATURE_TAG_RESET = 16'h3636;

	// Character roles on the result channel.
	localparam logic [1:0] ROLE_TAG = 2'd0;
	localparam logic [1:0] ROLE_LEN = 2'd1;
	localparam logic [1:0] ROLE_VAL = 2'd2;
	localparam logic [1:0] ROLE_IGN = 2'd3;

	// CRC-16/CCITT-FALSE constants.
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

	// The smallest frame that can carry a checksum.
	localparam logic [POS_W-1:0] MIN_FRAME_LAST = 10'd7;
	localparam logic [POS_W-1:0] TAIL_DEPTH     = 10'd4;

	// Largest element start offset that can be reported.
	localparam logic [OFFSET_W-1:0] OFFSET_SAT = 9'd511;

	// Control from the parser stage to the checksum unit.
	typedef struct packed {
		logic step;
		logic last;
		logic pos_ge4;
		logic pos_ge7;
	} crc_ctrl_t;

	// One byte of CRC-16, MSB first.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [CHAR_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Hex digit decode; bit 4 flags a valid digit.
	function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// File: rtl/qr_payload_tlv_parse_crc_check.sv
// Streaming TLV parser and CRC-16/CCITT-FALSE checker for QR payloads. Feed
// one character per transfer on the input channel, with last_char set on the
// final one; each character yields exactly one result transfer carrying its
// role (tag, length, value, or ignored past the element limit), the element
// tag, value position, element index and end-of-element mark. The result for
// the final character also carries the checksum verdict (the last four
// characters as hex against the CRC of everything before them), the count
// of complete elements and the start offset of the first element whose tag
// matches signature_tag. The block sustains one character per clock cycle
// when the result channel does not stall: the parse step and the byte-wide
// CRC step sit in a single stage between the input register and the result
// register. Frame state clears itself after the final character. The user
// must make configuration writes only between frames; this is not enforced.
module qr_payload_tlv_parse_crc_check
	import qrtlv_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64,
	parameter int MAX_PAYLOAD  = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	// Input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CHAR_W-1:0]    char_in,
	input  logic                 last_char,
	// Result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           role,
	output logic [TAG_W-1:0]     tag_code,
	output logic [CHAR_W-1:0]    value_char,
	output logic [LEN_W-1:0]     value_pos,
	output logic                 element_end,
	output logic [INDEX_W-1:0]   element_index,
	output logic                 frame_done,
	output logic                 crc_ok,
	output logic [COUNT_W-1:0]   element_count,
	output logic                 signature_found,
	output logic [OFFSET_W-1:0]  signature_offset
);

	// Parse phases.
	localparam logic [2:0] PH_TAG0     = 3'd0;
	localparam logic [2:0] PH_TAG1     = 3'd1;
	localparam logic [2:0] PH_LEN0     = 3'd2;
	localparam logic [2:0] PH_LEN1_OK  = 3'd3;
	localparam logic [2:0] PH_LEN1_BAD = 3'd4;
	localparam logic [2:0] PH_VALUE    = 3'd5;

	// Element limit ceiling and character counter saturation.
	localparam int ME_CLAMP = (MAX_ELEMENTS > 127) ? 127 : MAX_ELEMENTS;
	localparam logic [COUNT_W-1:0] ME_MAX = COUNT_W'(ME_CLAMP);
	localparam int POS_SAT_I = (MAX_PAYLOAD < 1023) ? MAX_PAYLOAD : 1023;
	localparam logic [POS_W-1:0] POS_SAT = POS_W'(POS_SAT_I);
	localparam logic [COUNT_W-1:0] COUNT_SAT = 7'd127;

	// Configuration registers
	logic [COUNT_W-1:0] max_elements_q;
	logic [TAG_W-1:0]   signature_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_elements_q  <= MAX_ELEMENTS_RESET;
			signature_tag_q <= SIGNATURE_TAG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_ELEMENTS:  max_elements_q  <= cfg_wdata[COUNT_W-1:0];
				CFG_SIGNATURE_TAG: signature_tag_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
	end

	// Frame state
	logic [2:0]          phase_q;
	logic [TAG_W-1:0]    tag_q;
	logic [LEN_W-1:0]    rem_q;
	logic [LEN_W-1:0]    vidx_q;
	logic [COUNT_W-1:0]  done_q;
	logic [POS_W-1:0]    pos_q;
	logic                sig_seen_q;
	logic [OFFSET_W-1:0] sig_pos_q;
	logic [OFFSET_W-1:0] estart_q;

	logic [2:0]          phase_n;
	logic [TAG_W-1:0]    tag_n;
	logic [LEN_W-1:0]    rem_n;
	logic [LEN_W-1:0]    vidx_n;
	logic [COUNT_W-1:0]  done_n;
	logic                sig_seen_n;
	logic [OFFSET_W-1:0] sig_pos_n;
	logic [OFFSET_W-1:0] estart_n;

	logic [COUNT_W-1:0]  limit;
	logic                is_digit;
	logic [3:0]          digit;
	logic [LEN_W-1:0]    len_sum;
	logic [LEN_W-1:0]    rem_dec;
	logic [1:0]          role_c;
	logic [LEN_W-1:0]    vpos_c;
	logic [INDEX_W-1:0]  idx_c;
	logic [TAG_W-1:0]    tag_out_c;
	logic                end_c;
	logic                crc_ok_c;
	crc_ctrl_t           crc_ctrl;

	// Effective limit: clamp to the ceiling, and zero acts as one.
	always_comb begin
		if (max_elements_q > ME_MAX) begin
			limit = ME_MAX;
		end else if (max_elements_q == '0) begin
			limit = 7'd1;
		end else begin
			limit = max_elements_q;
		end
	end

	assign is_digit = (char_s1 >= 8'h30) && (char_s1 <= 8'h39);
	assign digit    = char_s1[3:0];
	assign len_sum  = rem_q + {3'b000, digit};
	assign rem_dec  = (rem_q != '0) ? rem_q - 7'd1 : '0;

	// One parse step per character.
	always_comb begin
		phase_n    = phase_q;
		tag_n      = tag_q;
		rem_n      = rem_q;
		vidx_n     = vidx_q;
		done_n     = done_q;
		sig_seen_n = sig_seen_q;
		sig_pos_n  = sig_pos_q;
		estart_n   = estart_q;
		role_c     = ROLE_TAG;
		vpos_c     = '0;
		idx_c      = done_q[INDEX_W-1:0];
		tag_out_c  = '0;
		end_c      = 1'b0;

		if (phase_q == PH_TAG0 && done_q >= limit) begin
			role_c = ROLE_IGN;
			idx_c  = '0;
		end else begin
			unique case (phase_q)
				PH_TAG1: begin
					tag_n   = {tag_q[TAG_W-1:8], char_s1};
					phase_n = PH_LEN0;
				end
				PH_LEN0: begin
					role_c = ROLE_LEN;
					if (is_digit) begin
						// Tens digit times ten.
						rem_n   = {digit, 3'b000} + {2'b00, digit, 1'b0};
						phase_n = PH_LEN1_OK;
					end else begin
						rem_n   = '0;
						phase_n = PH_LEN1_BAD;
					end
				end
				PH_LEN1_OK, PH_LEN1_BAD: begin
					role_c = ROLE_LEN;
					rem_n  = (phase_q == PH_LEN1_OK && is_digit) ? len_sum : '0;
					vidx_n = '0;
					if (rem_n == '0) begin
						end_c = 1'b1;
					end else begin
						phase_n = PH_VALUE;
					end
				end
				PH_VALUE: begin
					role_c = ROLE_VAL;
					vpos_c = vidx_q;
					vidx_n = vidx_q + 7'd1;
					rem_n  = rem_dec;
					end_c  = (rem_dec == '0);
				end
				default: begin
					// First tag character, also any unused phase code.
					estart_n = (pos_q > POS_W'(OFFSET_SAT)) ? OFFSET_SAT
						: pos_q[OFFSET_W-1:0];
					tag_n    = {char_s1, 8'h00};
					phase_n  = PH_TAG1;
				end
			endcase

			tag_out_c = tag_n;
			if (end_c) begin
				if (!sig_seen_q && tag_n == signature_tag_q) begin
					sig_seen_n = 1'b1;
					sig_pos_n  = estart_n;
				end
				if (done_q < COUNT_SAT) begin
					done_n = done_q + 7'd1;
				end
				phase_n = PH_TAG0;
				rem_n   = '0;
				vidx_n  = '0;
			end
		end
	end

	// Checksum unit
	assign crc_ctrl.step    = advance;
	assign crc_ctrl.last    = last_s1;
	assign crc_ctrl.pos_ge4 = (pos_q >= TAIL_DEPTH);
	assign crc_ctrl.pos_ge7 = (pos_q >= MIN_FRAME_LAST);

	qrtlv_crc u_crc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (crc_ctrl),
		.char_cur (char_s1),
		.crc_ok   (crc_ok_c)
	);

	// Frame state update; everything returns to reset after the final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG0;
			tag_q      <= '0;
			rem_q      <= '0;
			vidx_q     <= '0;
			done_q     <= '0;
			pos_q      <= '0;
			sig_seen_q <= 1'b0;
			sig_pos_q  <= '0;
			estart_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q    <= PH_TAG0;
				tag_q      <= '0;
				rem_q      <= '0;
				vidx_q     <= '0;
				done_q     <= '0;
				pos_q      <= '0;
				sig_seen_q <= 1'b0;
				sig_pos_q  <= '0;
				estart_q   <= '0;
			end else begin
				phase_q    <= phase_n;
				tag_q      <= tag_n;
				rem_q      <= rem_n;
				vidx_q     <= vidx_n;
				done_q     <= done_n;
				sig_seen_q <= sig_seen_n;
				sig_pos_q  <= sig_pos_n;
				estart_q   <= estart_n;
				if (pos_q < POS_SAT) begin
					pos_q <= pos_q + 10'd1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			role             <= role_c;
			tag_code         <= tag_out_c;
			value_char       <= char_s1;
			value_pos        <= vpos_c;
			element_end      <= end_c;
			element_index    <= idx_c;
			frame_done       <= last_s1;
			crc_ok           <= crc_ok_c;
			element_count    <= last_s1 ? done_n : '0;
			signature_found  <= last_s1 & sig_seen_n;
			signature_offset <= (last_s1 && sig_seen_n) ? sig_pos_n : '0;
		end
	end

	// Frame summary fields stay zero except on the final character.
	a_summary_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> !crc_ok && element_count == '0
			&& !signature_found && signature_offset == '0)
		else $error("frame summary set on a character that is not the last");

	// Ignored characters carry no element information.
	a_ignored_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && role == ROLE_IGN |-> tag_code == '0 && element_index == '0
			&& !element_end && value_pos == '0)
		else $error("ignored character carries element information");

	// The final character leaves the parser at the start of a fresh frame.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> phase_q == PH_TAG0 && done_q == '0 && pos_q == '0
			&& !sig_seen_q)
		else $error("frame state not cleared after the final character");

	// The parser never counts past the element limit.
	a_count_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= limit || $past(cfg_we))
		else $error("element count exceeds the element limit");

endmodule

// File: rtl/qrtlv_crc.sv
module qrtlv_crc
	import qrtlv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  crc_ctrl_t         ctrl,
	input  logic [CHAR_W-1:0] char_cur,
	output logic              crc_ok
);

	logic [CRC_W-1:0]  crc_q;
	logic [CHAR_W-1:0] tail_q [4];
	logic [CRC_W-1:0]  crc_next;
	logic [CRC_W-1:0]  given;
	logic              all_hex;
	logic [4:0]        h0, h1, h2, h3;

	// The byte leaving the four-deep delay line enters the CRC.
	assign crc_next = ctrl.pos_ge4 ? crc_byte(crc_q, tail_q[0]) : crc_q;

	// The trailing four characters, as they stand after this shift.
	assign h0      = hex_decode(tail_q[1]);
	assign h1      = hex_decode(tail_q[2]);
	assign h2      = hex_decode(tail_q[3]);
	assign h3      = hex_decode(char_cur);
	assign all_hex = h0[4] & h1[4] & h2[4] & h3[4];
	assign given   = {h0[3:0], h1[3:0], h2[3:0], h3[3:0]};
	assign crc_ok  = ctrl.last && ctrl.pos_ge7 && all_hex && (given == crc_next);

	// Running CRC and delay line; both restart after the final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			for (int i = 0; i < 4; i++) begin
				tail_q[i] <= '0;
			end
		end else if (ctrl.step) begin
			if (ctrl.last) begin
				crc_q <= CRC_INIT;
				for (int i = 0; i < 4; i++) begin
					tail_q[i] <= '0;
				end
			end else begin
				crc_q     <= crc_next;
				tail_q[0] <= tail_q[1];
				tail_q[1] <= tail_q[2];
				tail_q[2] <= tail_q[3];
				tail_q[3] <= char_cur;
			end
		end
	end

endmodule

// File: dv/qr_tlv_checker.sv
`timescale 1ns / 100ps

module qr_tlv_checker
	import qrtlv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [CHAR_W-1:0]    char_in,
	input  logic                 last_char,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [1:0]           role,
	input  logic [TAG_W-1:0]     tag_code,
	input  logic [CHAR_W-1:0]    value_char,
	input  logic [LEN_W-1:0]     value_pos,
	input  logic                 element_end,
	input  logic [INDEX_W-1:0]   element_index,
	input  logic                 frame_done,
	input  logic                 crc_ok,
	input  logic [COUNT_W-1:0]   element_count,
	input  logic                 signature_found,
	input  logic [OFFSET_W-1:0]  signature_offset,
	output int                   fail_count,
	output int                   pending
);

	// Build-time sizes of the block under test and checksum constants.
	localparam int ELEM_CAP   = 64;
	localparam int POS_CAP    = 512;
	localparam int OFFSET_CAP = 511;
	localparam logic [CRC_W-1:0] GEN_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;

	// Where the parser stands inside the current element.
	typedef enum logic [2:0] {
		WAIT_TAG_HI,
		WAIT_TAG_LO,
		WAIT_LEN_HI,
		WAIT_LEN_LO,
		WAIT_LEN_LO_BAD,
		IN_VALUE
	} parse_state_t;

	// One predicted character result.
	typedef struct packed {
		logic [1:0]          role;
		logic [TAG_W-1:0]    tag;
		logic [CHAR_W-1:0]   ch;
		logic [LEN_W-1:0]    pos;
		logic                eend;
		logic [INDEX_W-1:0]  idx;
		logic                done;
		logic                crc_ok;
		logic [COUNT_W-1:0]  count;
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} char_result_t;

	logic [COUNT_W-1:0]     max_elem_cfg;
	logic [TAG_W-1:0]       sig_tag_cfg;

	parse_state_t           state;
	logic [TAG_W-1:0]       tag_acc;
	logic [LEN_W-1:0]       len_left;
	logic [LEN_W-1:0]       val_idx;
	logic [COUNT_W-1:0]     elems;
	logic [CRC_W-1:0]       crc_acc;
	logic [3:0][CHAR_W-1:0] tail;
	logic [POS_W-1:0]       char_pos;
	logic                   sig_hit;
	logic [OFFSET_W-1:0]    sig_at;
	logic [OFFSET_W-1:0]    elem_at;

	char_result_t           result_q[$];

	// Bit-serial CRC-16, most significant bit of the byte first.
	function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
			input logic [CHAR_W-1:0] b);
		logic [CRC_W-1:0] r;
		logic fb;
		r = crc;
		for (int i = CHAR_W - 1; i >= 0; i--) begin
			fb = r[CRC_W-1] ^ b[i];
			r = r << 1;
			if (fb) begin
				r = r ^ GEN_POLY;
			end
		end
		return r;
	endfunction

	function automatic int hex_digit(input logic [CHAR_W-1:0] c);
		if (c >= "0" && c <= "9") begin
			return c - "0";
		end
		if (c >= "A" && c <= "F") begin
			return c - "A" + 10;
		end
		if (c >= "a" && c <= "f") begin
			return c - "a" + 10;
		end
		return -1;
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Everything but the registers goes back to its idle value between frames.
	task automatic clear_frame();
		state = WAIT_TAG_HI;
		tag_acc = '0;
		len_left = '0;
		val_idx = '0;
		elems = '0;
		crc_acc = CRC_SEED;
		tail = '0;
		char_pos = '0;
		sig_hit = 1'b0;
		sig_at = '0;
		elem_at = '0;
	endtask

	// Advance the frame state by one character and work out its result.
	task automatic predict_char(input logic [CHAR_W-1:0] c, input logic last,
			output char_result_t r);
		int limit;
		int len;
		int given;
		int nib;
		logic tail_ok;
		r = '0;
		r.ch = c;
		r.done = last;
		limit = (max_elem_cfg > ELEM_CAP) ? ELEM_CAP : max_elem_cfg;
		if (limit == 0) begin
			limit = 1;
		end
		r.idx = elems[INDEX_W-1:0];

		if (state == WAIT_TAG_HI && elems >= limit) begin
			// Past the element limit the character is only passed through.
			r.role = ROLE_IGN;
			r.idx = '0;
		end else begin
			case (state)
				WAIT_TAG_LO: begin
					r.role = ROLE_TAG;
					tag_acc[7:0] = c;
					state = WAIT_LEN_HI;
				end
				WAIT_LEN_HI: begin
					r.role = ROLE_LEN;
					if (is_digit(c)) begin
						len = (c - "0") * 10;
						len_left = len[LEN_W-1:0];
						state = WAIT_LEN_LO;
					end else begin
						len_left = '0;
						state = WAIT_LEN_LO_BAD;
					end
				end
				WAIT_LEN_LO, WAIT_LEN_LO_BAD: begin
					r.role = ROLE_LEN;
					len = (state == WAIT_LEN_LO && is_digit(c)) ? len_left + (c - "0") : 0;
					len_left = len[LEN_W-1:0];
					val_idx = '0;
					if (len == 0) begin
						r.eend = 1'b1;
					end else begin
						state = IN_VALUE;
					end
				end
				IN_VALUE: begin
					r.role = ROLE_VAL;
					r.pos = val_idx;
					val_idx = val_idx + 1'b1;
					if (len_left > 0) begin
						len_left = len_left - 1'b1;
					end
					if (len_left == 0) begin
						r.eend = 1'b1;
					end
				end
				default: begin
					r.role = ROLE_TAG;
					elem_at = (char_pos > OFFSET_CAP) ? OFFSET_CAP[OFFSET_W-1:0]
						: char_pos[OFFSET_W-1:0];
					tag_acc = {c, 8'h00};
					state = WAIT_TAG_LO;
				end
			endcase
			r.tag = tag_acc;

			// A completed element may be the first signature element.
			if (r.eend) begin
				if (!sig_hit && tag_acc == sig_tag_cfg) begin
					sig_hit = 1'b1;
					sig_at = elem_at;
				end
				if (elems < 127) begin
					elems = elems + 1'b1;
				end
				state = WAIT_TAG_HI;
				len_left = '0;
				val_idx = '0;
			end
		end

		// The checksum trails the input by four characters.
		if (char_pos >= 4) begin
			crc_acc = crc16_update(crc_acc, tail[0]);
		end
		tail = {c, tail[3:1]};

		if (last) begin
			if (char_pos >= 7) begin
				tail_ok = 1'b1;
				given = 0;
				for (int i = 0; i < 4; i++) begin
					nib = hex_digit(tail[i]);
					if (nib < 0) begin
						tail_ok = 1'b0;
					end else begin
						given = (given << 4) | nib;
					end
				end
				r.crc_ok = tail_ok && (given[15:0] == crc_acc);
			end
			r.count = elems;
			r.found = sig_hit;
			r.offset = sig_hit ? sig_at : '0;
		end

		if (char_pos < POS_CAP) begin
			char_pos = char_pos + 1'b1;
		end
		if (last) begin
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Register writes, result comparison and prediction, all at the rising edge.
	always @(posedge clk or negedge arst_n) begin : track
		char_result_t want;
		if (!arst_n) begin
			max_elem_cfg = MAX_ELEMENTS_RESET;
			sig_tag_cfg = SIGNATURE_TAG_RESET;
			clear_frame();
			result_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_ELEMENTS: begin
						max_elem_cfg = cfg_wdata[COUNT_W-1:0];
					end
					CFG_SIGNATURE_TAG: begin
						sig_tag_cfg = cfg_wdata[TAG_W-1:0];
					end
					default: begin
					end
				endcase
			end

			// A result transfer is matched against the oldest prediction.
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected, char 0x%0h",
						$time, value_char);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					check_field("role", want.role, role);
					check_field("tag_code", want.tag, tag_code);
					check_field("value_char", want.ch, value_char);
					check_field("value_pos", want.pos, value_pos);
					check_field("element_end", want.eend, element_end);
					check_field("element_index", want.idx, element_index);
					check_field("frame_done", want.done, frame_done);
					check_field("crc_ok", want.crc_ok, crc_ok);
					check_field("element_count", want.count, element_count);
					check_field("signature_found", want.found, signature_found);
					check_field("signature_offset", want.offset, signature_offset);
				end
			end

			if (in_valid && in_ready) begin
				predict_char(char_in, last_char, want);
				result_q.push_back(want);
			end
			pending = result_q.size();
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import qrtlv_pkg::*;

	// Cycles without any transfer before the run is called hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles of quiet after the last result before a register write.
	localparam int DRAIN_HOLD  = 4;
	localparam int PHASE_CHARS = 110;
	localparam int PHASES      = 6;

	// Ways of closing a frame with its checksum.
	localparam int TAIL_UPPER   = 0;
	localparam int TAIL_LOWER   = 1;
	localparam int TAIL_WRONG   = 2;
	localparam int TAIL_NOT_HEX = 3;

	// Receiver behaviors.
	localparam int SINK_OPEN = 0;
	localparam int SINK_HOLD = 1;
	localparam int SINK_COIN = 2;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [CHAR_W-1:0]    char_in;
	logic                 last_char;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           role;
	logic [TAG_W-1:0]     tag_code;
	logic [CHAR_W-1:0]    value_char;
	logic [LEN_W-1:0]     value_pos;
	logic                 element_end;
	logic [INDEX_W-1:0]   element_index;
	logic                 frame_done;
	logic                 crc_ok;
	logic [COUNT_W-1:0]   element_count;
	logic                 signature_found;
	logic [OFFSET_W-1:0]  signature_offset;

	int                   fail_cnt;
	int                   pending_cnt;
	int                   idle_cycles = 0;
	int                   burst_left = 0;
	logic [CHAR_W-1:0]    frame_q[$];
	logic [TAG_W-1:0]     sig_tag_now;

	qr_payload_tlv_parse_crc_check i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.char_in          (char_in),
		.last_char        (last_char),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.role             (role),
		.tag_code         (tag_code),
		.value_char       (value_char),
		.value_pos        (value_pos),
		.element_end      (element_end),
		.element_index    (element_index),
		.frame_done       (frame_done),
		.crc_ok           (crc_ok),
		.element_count    (element_count),
		.signature_found  (signature_found),
		.signature_offset (signature_offset)
	);

	qr_tlv_checker i_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.char_in          (char_in),
		.last_char        (last_char),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.role             (role),
		.tag_code         (tag_code),
		.value_char       (value_char),
		.value_pos        (value_pos),
		.element_end      (element_end),
		.element_index    (element_index),
		.frame_done       (frame_done),
		.crc_ok           (crc_ok),
		.element_count    (element_count),
		.signature_found  (signature_found),
		.signature_offset (signature_offset),
		.fail_count       (fail_cnt),
		.pending          (pending_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: runs of always ready, hard stalls and coin flips.
	initial begin : sink
		int run;
		int mode;
		out_ready = 1'b0;
		run = 0;
		mode = SINK_OPEN;
		forever begin
			@(negedge clk);
			if (run == 0) begin
				mode = $urandom_range(SINK_OPEN, SINK_COIN);
				run = (mode == SINK_HOLD) ? $urandom_range(1, 6) : $urandom_range(1, 30);
			end
			case (mode)
				SINK_OPEN: begin
					out_ready = 1'b1;
				end
				SINK_HOLD: begin
					out_ready = 1'b0;
				end
				default: begin
					out_ready = $urandom_range(0, 1);
				end
			endcase
			run--;
		end
	end

	// Hang detection: any transfer restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Checksum of the frame built so far, as the trailing digits carry it.
	function automatic logic [CRC_W-1:0] frame_crc();
		logic [CRC_W-1:0] r;
		logic fb;
		r = CRC_INIT;
		foreach (frame_q[k]) begin
			for (int i = CHAR_W - 1; i >= 0; i--) begin
				fb = r[CRC_W-1] ^ frame_q[k][i];
				r = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
			end
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n, input logic lower);
		if (n < 10) begin
			return 8'h30 + n;
		end
		return (lower ? 8'h61 : 8'h41) + n - 10;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_non_digit();
		logic [CHAR_W-1:0] c;
		do begin
			c = $urandom_range(0, 255);
		end while (c >= "0" && c <= "9");
		return c;
	endfunction

	// Mostly two decimal digits, sometimes the signature tag or raw bytes.
	function automatic logic [TAG_W-1:0] rand_tag();
		logic [CHAR_W-1:0] hi;
		logic [CHAR_W-1:0] lo;
		int pick;
		pick = $urandom_range(0, 9);
		hi = 8'h30 + $urandom_range(0, 9);
		lo = 8'h30 + $urandom_range(0, 9);
		if (pick < 2) begin
			return sig_tag_now;
		end
		if (pick == 2) begin
			return $urandom_range(0, 16'hFFFF);
		end
		return {hi, lo};
	endfunction

	function automatic int rand_len();
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(13, 99);
		end
		return $urandom_range(0, 12);
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			frame_q.push_back(s[i]);
		end
	endtask

	task automatic push_element(input logic [TAG_W-1:0] tag, input int len);
		frame_q.push_back(tag[15:8]);
		frame_q.push_back(tag[7:0]);
		frame_q.push_back(8'h30 + len / 10);
		frame_q.push_back(8'h30 + len % 10);
		repeat (len) frame_q.push_back($urandom_range(0, 255));
	endtask

	// Close the frame with a checksum element, correct or spoiled.
	task automatic push_check_tail(input int mode);
		logic [CRC_W-1:0] sum;
		int spot;
		push_text("6304");
		sum = frame_crc();
		spot = $urandom_range(0, 3);
		if (mode == TAIL_WRONG) begin
			sum = sum ^ ($urandom_range(1, 15) << (4 * spot));
		end
		for (int i = 3; i >= 0; i--) begin
			frame_q.push_back(hex_char(sum[4*i +: 4], mode == TAIL_LOWER));
		end
		if (mode == TAIL_NOT_HEX) begin
			frame_q[frame_q.size() - 4 + spot] = $urandom_range(0, 1)
				? 8'h47 + $urandom_range(0, 19) : 8'h80 + $urandom_range(0, 127);
		end
	endtask

	// One character transfer; bursts of random length with gaps between them.
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		in_valid = 1'b1;
		char_in = c;
		last_char = last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++) begin
			send_char(frame_q[i], i == frame_q.size() - 1);
		end
		frame_q.delete();
	endtask

	// Hold the sender until every predicted result has come back.
	task automatic drain();
		in_valid = 1'b0;
		burst_left = 0;
		while (pending_cnt != 0) @(negedge clk);
		repeat (DRAIN_HOLD) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Unused upper data bits of the element limit are filled at random.
	task automatic set_config(input int max_val, input logic [TAG_W-1:0] sig_val);
		drain();
		cfg_write(CFG_MAX_ELEMENTS, ($urandom_range(0, 511) << COUNT_W) | max_val);
		cfg_write(CFG_SIGNATURE_TAG, sig_val);
		sig_tag_now = sig_val;
	endtask

	// Mostly well-formed frames; also broken lengths, cut-off frames and noise.
	task automatic build_random_frame();
		int kind;
		int n;
		int len;
		int cut;
		int tail_pick;
		logic [TAG_W-1:0] tag;
		kind = $urandom_range(0, 99);
		n = $urandom_range(1, 5);
		if (kind < 62) begin
			repeat (n) push_element(rand_tag(), rand_len());
			tail_pick = $urandom_range(0, 9);
			if (tail_pick == 0) begin
				push_check_tail(TAIL_WRONG);
			end else if (tail_pick == 1) begin
				push_check_tail(TAIL_NOT_HEX);
			end else begin
				push_check_tail($urandom_range(TAIL_UPPER, TAIL_LOWER));
			end
		end else if (kind < 74) begin
			repeat (n) begin
				if ($urandom_range(0, 1) == 0) begin
					push_element(rand_tag(), rand_len());
				end else begin
					tag = rand_tag();
					frame_q.push_back(tag[15:8]);
					frame_q.push_back(tag[7:0]);
					if ($urandom_range(0, 1) == 0) begin
						frame_q.push_back(rand_non_digit());
						frame_q.push_back($urandom_range(0, 255));
					end else begin
						frame_q.push_back(8'h30 + $urandom_range(0, 9));
						frame_q.push_back(rand_non_digit());
					end
				end
			end
			push_check_tail(TAIL_UPPER);
		end else if (kind < 86) begin
			repeat (n - 1) push_element(rand_tag(), rand_len());
			len = rand_len();
			push_element(rand_tag(), len);
			cut = $urandom_range(1, 3 + len);
			repeat (cut) void'(frame_q.pop_back());
		end else begin
			repeat ($urandom_range(1, 16)) frame_q.push_back($urandom_range(0, 255));
		end
	endtask

	initial begin : stimulus
		int ph;
		int phase_chars;
		int max_val;
		logic [TAG_W-1:0] sig_val;
		logic [CHAR_W-1:0] digit;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		char_in = '0;
		last_char = 1'b0;
		sig_tag_now = SIGNATURE_TAG_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames under the reset configuration.
		// Zero-length signature element, then a good checksum.
		push_text("0002016600");
		push_check_tail(TAIL_UPPER);
		send_frame();
		// Lower-case checksum digits.
		push_text("0102AB");
		push_check_tail(TAIL_LOWER);
		send_frame();
		// Non-digit length in either position gives a zero-length element.
		push_text("59A1591x");
		push_check_tail(TAIL_UPPER);
		send_frame();
		// Too short to carry a checksum, and a single-character frame.
		push_text("0003abc");
		send_frame();
		push_text("6");
		send_frame();
		// Smallest frame with a correct checksum, and one with a wrong one.
		push_check_tail(TAIL_UPPER);
		send_frame();
		push_text("63041234");
		send_frame();
		// A non-hex character among the trailing digits.
		push_text("0102AB");
		push_check_tail(TAIL_NOT_HEX);
		send_frame();
		// A signature element cut off by the end of the frame does not count.
		push_text("0002AB6605ab");
		send_frame();
		// Two signature elements: the first one is reported.
		push_text("6601X6601Y");
		push_check_tail(TAIL_UPPER);
		send_frame();
		// Long frame: full-length values, the element limit, a signature
		// element past the offset range and the character counter saturating.
		for (int i = 0; i < 3; i++) begin
			push_element(rand_tag(), 99);
		end
		for (int i = 0; i < 60; i++) begin
			digit = 8'h30 + $urandom_range(0, 9);
			push_element({8'h30, digit}, 0);
		end
		push_element(sig_tag_now, 2);
		push_check_tail(TAIL_LOWER);
		send_frame();
		// The sender waits for every result before going on.
		drain();

		// Random frames under a sequence of register settings.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					max_val = 0;
					sig_val = "00";
				end
				1: begin
					max_val = 127;
					sig_val = 16'hFFFF;
				end
				2: begin
					max_val = 1;
					sig_val = 16'h0000;
				end
				3: begin
					max_val = $urandom_range(2, 8);
					sig_val = {8'h30 + 8'($urandom_range(0, 9)), 8'h30 + 8'($urandom_range(0, 9))};
				end
				4: begin
					max_val = 64;
					sig_val = SIGNATURE_TAG_RESET;
				end
				default: begin
					max_val = $urandom_range(1, 64);
					sig_val = $urandom_range(0, 16'hFFFF);
				end
			endcase
			set_config(max_val, sig_val);
			phase_chars = 0;
			while (phase_chars < PHASE_CHARS) begin
				build_random_frame();
				phase_chars += frame_q.size();
				send_frame();
				if ($urandom_range(0, 7) == 0) begin
					drain();
				end
			end
		end

		drain();
		if (fail_cnt == 0 && pending_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
